[rtl/blel_pkg.sv]
// Package for the bounded list engine: opcodes, status codes, beat structs, sequencer states.
package blel_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // opcodes
   localparam logic [3:0] OP_APPEND    = 4'd0;
   localparam logic [3:0] OP_SET       = 4'd1;
   localparam logic [3:0] OP_SET_EXT   = 4'd2;
   localparam logic [3:0] OP_LOOKUP    = 4'd3;
   localparam logic [3:0] OP_REM_POS   = 4'd4;
   localparam logic [3:0] OP_REM_ORD   = 4'd5;
   localparam logic [3:0] OP_REM_SWAP  = 4'd6;
   localparam logic [3:0] OP_CLEAR     = 4'd7;
   localparam logic [3:0] OP_RESIZE    = 4'd8;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [5:0]  position_in;
      logic [31:0] item_value;
      logic [6:0]  new_length;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [5:0] match_position;
      logic [6:0] length_now;
      logic [1:0] status;
   } rsp_type;

   // walk unit command: issue a read, either at a loaded index or at index + 1
   typedef struct packed {
      logic issue;
      logic load;
   } walk_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SHIFT_START,
      S_SHIFT,
      S_SWAP_RD,
      S_SWAP_WR,
      S_ZERO,
      S_PUT
   } state_type;

endpackage

[rtl/blel_mem.sv]
// Entry store: one write port, one read port with registered read data.
module blel_mem #(
   parameter int DEPTH = blel_pkg::CAPACITY_DEF,
   parameter int WIDTH = blel_pkg::VALUE_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             re,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import blel_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/blel_walk.sv]
// Walk unit: shared index counter, +1/-1 arithmetic and the value comparator.
module blel_walk #(
   parameter int LW = 7,
   parameter int AW = 6,
   parameter int VW = blel_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  blel_pkg::walk_cmd_type cmd,
   input  logic [LW-1:0]          load_idx,
   input  logic [VW-1:0]          rd_data,
   input  logic [VW-1:0]          key,
   output logic [AW-1:0]          rd_addr,
   output logic                   rd_en,
   output logic [LW-1:0]          idx,
   output logic [LW-1:0]          nxt,
   output logic [LW-1:0]          prv,
   output logic                   eq
);
   import blel_pkg::*;

   logic [LW-1:0] idx_ff;
   logic [LW-1:0] idx_in;
   logic [LW-1:0] issue_idx;

   // idx_ff tracks the address whose word sits in the read register
   assign nxt       = idx_ff + LW'(1);
   assign prv       = idx_ff - LW'(1);
   assign issue_idx = cmd.load ? load_idx : nxt;
   assign idx_in    = cmd.issue ? issue_idx : idx_ff;
   assign rd_addr   = issue_idx[AW-1:0];
   assign rd_en     = cmd.issue;
   assign idx       = idx_ff;
   assign eq        = (rd_data == key);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[rtl/blel_ctrl.sv]
// Sequencer: request register, live count, per-opcode steps and response fields.
module blel_ctrl #(
   parameter int CAPACITY = blel_pkg::CAPACITY_DEF,
   parameter int VW       = blel_pkg::VALUE_WIDTH_DEF,
   parameter int LW       = $clog2(CAPACITY + 1),
   parameter int AW       = $clog2(CAPACITY)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  blel_pkg::req_type      req,
   output logic                   busy,
   output blel_pkg::walk_cmd_type cmd,
   output logic [LW-1:0]          load_idx,
   output logic [VW-1:0]          key,
   input  logic [LW-1:0]          idx,
   input  logic [LW-1:0]          nxt,
   input  logic [LW-1:0]          prv,
   input  logic                   eq,
   input  logic [VW-1:0]          rd_data,
   output logic                   we,
   output logic [AW-1:0]          wr_addr,
   output logic [VW-1:0]          wr_data,
   output logic                   done,
   output blel_pkg::rsp_type      done_rsp
);
   import blel_pkg::*;

   localparam int CW = (LW > 7) ? LW : 7;

   state_type     state_ff, state_in;
   req_type       req_ff;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] hit_ff, hit_in;

   logic [CW-1:0] pos_c, len_c, nlen_c, cap_c;
   logic [LW-1:0] pos_l, nlen_l, zero_end;

   generate
      if (VW <= 32) begin : g_key_narrow
         assign key = req_ff.item_value[VW-1:0];
      end else begin : g_key_wide
         assign key = {{(VW - 32){1'b0}}, req_ff.item_value};
      end
   endgenerate

   assign pos_c    = CW'(req_ff.position_in);
   assign len_c    = CW'(len_ff);
   assign nlen_c   = CW'(req_ff.new_length);
   assign cap_c    = CW'(CAPACITY);
   assign pos_l    = pos_c[LW-1:0];
   assign nlen_l   = nlen_c[LW-1:0];
   assign zero_end = (req_ff.opcode == OP_RESIZE) ? nlen_l : pos_l;
   assign busy     = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req;
      end
      hit_ff <= hit_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (req_ff.opcode)
               OP_LOOKUP, OP_REM_ORD, OP_REM_SWAP: begin
                  if (len_ff != '0) state_in = S_SCAN;
               end
               OP_SET_EXT: begin
                  if (pos_c < cap_c && pos_c > len_c) state_in = S_ZERO;
               end
               OP_RESIZE: begin
                  if (nlen_c <= cap_c && nlen_c > len_c) state_in = S_ZERO;
               end
               OP_REM_POS: begin
                  if (pos_c < len_c) state_in = S_SHIFT_START;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (eq) begin
               if (req_ff.opcode == OP_LOOKUP)      state_in = S_IDLE;
               else if (req_ff.opcode == OP_REM_ORD) state_in = S_SHIFT_START;
               else                                  state_in = S_SWAP_RD;
            end else if (nxt == len_ff) begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT_START, S_SHIFT: begin
            state_in = (nxt == len_ff) ? S_IDLE : S_SHIFT;
         end
         S_SWAP_RD: state_in = S_SWAP_WR;
         S_SWAP_WR: state_in = S_IDLE;
         S_ZERO: begin
            if (nxt == zero_end) begin
               state_in = (req_ff.opcode == OP_SET_EXT) ? S_PUT : S_IDLE;
            end
         end
         S_PUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd      = '0;
      load_idx = '0;
      we       = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      len_in   = len_ff;
      hit_in   = hit_ff;
      done     = 1'b0;
      done_rsp = '0;
      done_rsp.status = ST_OK;
      case (state_ff)
         S_DECODE: begin
            case (req_ff.opcode)
               OP_APPEND: begin
                  done = 1'b1;
                  if (len_c >= cap_c) begin
                     done_rsp.status = ST_FULL;
                  end else begin
                     we      = 1'b1;
                     wr_addr = len_ff[AW-1:0];
                     wr_data = key;
                     len_in  = len_ff + LW'(1);
                  end
               end
               OP_SET: begin
                  done = 1'b1;
                  if (pos_c >= len_c) begin
                     done_rsp.status = ST_RANGE;
                  end else begin
                     we      = 1'b1;
                     wr_addr = pos_l[AW-1:0];
                     wr_data = key;
                  end
               end
               OP_SET_EXT: begin
                  if (pos_c >= cap_c) begin
                     done            = 1'b1;
                     done_rsp.status = ST_RANGE;
                  end else if (pos_c > len_c) begin
                     cmd.issue = 1'b1;
                     cmd.load  = 1'b1;
                     load_idx  = len_ff;
                  end else begin
                     done    = 1'b1;
                     we      = 1'b1;
                     wr_addr = pos_l[AW-1:0];
                     wr_data = key;
                     if (pos_c == len_c) len_in = pos_l + LW'(1);
                  end
               end
               OP_LOOKUP, OP_REM_ORD, OP_REM_SWAP: begin
                  if (len_ff == '0) begin
                     done            = 1'b1;
                     done_rsp.status = ST_NOT_FOUND;
                  end else begin
                     cmd.issue = 1'b1;
                     cmd.load  = 1'b1;
                  end
               end
               OP_REM_POS: begin
                  if (pos_c >= len_c) begin
                     done            = 1'b1;
                     done_rsp.status = ST_RANGE;
                  end else begin
                     cmd.issue = 1'b1;
                     cmd.load  = 1'b1;
                     load_idx  = pos_l;
                  end
               end
               OP_CLEAR: begin
                  done   = 1'b1;
                  len_in = '0;
               end
               OP_RESIZE: begin
                  if (nlen_c > cap_c) begin
                     done            = 1'b1;
                     done_rsp.status = ST_FULL;
                  end else if (nlen_c > len_c) begin
                     cmd.issue = 1'b1;
                     cmd.load  = 1'b1;
                     load_idx  = len_ff;
                  end else begin
                     done   = 1'b1;
                     len_in = nlen_l;
                  end
               end
               default: done = 1'b1;
            endcase
         end
         S_SCAN: begin
            if (eq) begin
               hit_in = idx[AW-1:0];
               if (req_ff.opcode == OP_LOOKUP) begin
                  done                    = 1'b1;
                  done_rsp.found          = 1'b1;
                  done_rsp.match_position = 6'(idx);
               end
            end else if (nxt == len_ff) begin
               done            = 1'b1;
               done_rsp.status = ST_NOT_FOUND;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_SHIFT_START, S_SHIFT: begin
            if (state_ff == S_SHIFT) begin
               we      = 1'b1;
               wr_addr = prv[AW-1:0];
               wr_data = rd_data;
            end
            if (nxt == len_ff) begin
               done   = 1'b1;
               len_in = len_ff - LW'(1);
               if (req_ff.opcode == OP_REM_ORD) begin
                  done_rsp.found          = 1'b1;
                  done_rsp.match_position = 6'(hit_ff);
               end
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_SWAP_RD: begin
            cmd.issue = 1'b1;
            cmd.load  = 1'b1;
            load_idx  = len_ff - LW'(1);
         end
         S_SWAP_WR: begin
            we                      = 1'b1;
            wr_addr                 = hit_ff;
            wr_data                 = rd_data;
            len_in                  = len_ff - LW'(1);
            done                    = 1'b1;
            done_rsp.found          = 1'b1;
            done_rsp.match_position = 6'(hit_ff);
         end
         S_ZERO: begin
            we      = 1'b1;
            wr_addr = idx[AW-1:0];
            if (nxt == zero_end) begin
               if (req_ff.opcode == OP_RESIZE) begin
                  done   = 1'b1;
                  len_in = nlen_l;
               end
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_PUT: begin
            we      = 1'b1;
            wr_addr = pos_l[AW-1:0];
            wr_data = key;
            len_in  = pos_l + LW'(1);
            done    = 1'b1;
         end
         default: begin
            done = 1'b0;
         end
      endcase
      done_rsp.length_now = 7'(len_in);
   end

`ifndef ASSERT_OFF
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == S_IDLE))
      else $error("response beat while the sequencer keeps running");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWAP_WR) |-> ($past(state_ff) == S_SWAP_RD))
      else $error("swap write without fetch of the last entry");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      done |-> (CW'(len_in) <= cap_c))
      else $error("count beyond capacity");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx < len_ff))
      else $error("search beyond the live count");
`endif

endmodule

[rtl/bounded_list_engine_unit.sv]
// Top level of the bounded list engine: sequencer, walk unit, entry store, response register.
//
// A list of up to CAPACITY words of VALUE_WIDTH bits with a live count. Raise start with
// a request beat on req_data while busy is low; the beat is taken at that clock edge and
// busy stays high until the response is out. Every request gives exactly one response
// beat: rsp_valid is high for a single cycle with rsp_data, and there is no way to hold
// it off, so the receiver must take it then. A new request may be given in the cycle the
// response is shown. Append, set, clear, an undefined opcode, any rejected request and
// set_extend or resize that expose no slot answer straight from the decode state; lookup
// and the value removals walk the list through the single read port of the entry store
// one entry a cycle, stopping at a hit or at the end of the list; remove_ordered then
// shifts each later entry down one slot, remove_pos shifts the entries after its
// position down, remove_swap moves the last entry into the hit slot; set_extend and
// resize write zeros into every exposed slot before they finish (set_extend then writes
// its own slot). The store needs no clearing after reset: slots past the count are never
// compared or copied and are zeroed when exposed.
module bounded_list_engine_unit #(
   parameter int CAPACITY    = blel_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = blel_pkg::VALUE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  blel_pkg::req_type req_data,
   output logic              rsp_valid,
   output blel_pkg::rsp_type rsp_data
);
   import blel_pkg::*;

   localparam int LW = $clog2(CAPACITY + 1);  // count, holds CAPACITY itself
   localparam int AW = $clog2(CAPACITY);      // store address

   walk_cmd_type     cmd;
   logic [LW-1:0]    load_idx;
   logic [VALUE_WIDTH-1:0] key;
   logic [LW-1:0]    idx, nxt, prv;
   logic             eq;
   logic [AW-1:0]    rd_addr;
   logic             rd_en;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic             we;
   logic [AW-1:0]    wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic             done;
   rsp_type          done_rsp;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   // sequencer: decodes the beat, owns the count, drives the store and walk unit
   blel_ctrl #(
      .CAPACITY (CAPACITY),
      .VW       (VALUE_WIDTH),
      .LW       (LW),
      .AW       (AW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .busy     (busy),
      .cmd      (cmd),
      .load_idx (load_idx),
      .key      (key),
      .idx      (idx),
      .nxt      (nxt),
      .prv      (prv),
      .eq       (eq),
      .rd_data  (rd_data),
      .we       (we),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .done     (done),
      .done_rsp (done_rsp)
   );

   // shared index/compare unit used by search, shift, swap and zero fill
   blel_walk #(
      .LW (LW),
      .AW (AW),
      .VW (VALUE_WIDTH)
   ) u_walk (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .load_idx (load_idx),
      .rd_data  (rd_data),
      .key      (key),
      .rd_addr  (rd_addr),
      .rd_en    (rd_en),
      .idx      (idx),
      .nxt      (nxt),
      .prv      (prv),
      .eq       (eq)
   );

   // entry store, one write and one registered read a cycle
   blel_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .we      (we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .re      (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register: one-cycle strobe, payload held until the next response
   assign rsp_valid_in = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= done_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sim/bounded_list_engine_unit_tb.sv]
// Self-checking testbench for the bounded list engine: directed table, then random list traffic.
module bounded_list_engine_unit_tb;
   import blel_pkg::*;

   localparam int LIST_CAP      = CAPACITY_DEF;
   localparam int RANDOM_BEATS  = 1500;
   localparam int STALL_LIMIT   = 4000;   // worst beat is a full-list walk plus sender gaps
   localparam int DRAIN_CYCLES  = LIST_CAP + 8;
   localparam int QUIET_FROM    = 600;    // request beats in this window go out back to back
   localparam int QUIET_TO      = 1000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   bounded_list_engine_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Expected list contents, kept in step with every accepted request beat
   // ---------------------------------------------------------------------------------------
   logic [31:0] list_words [LIST_CAP];
   int unsigned list_count;

   rsp_type replies_due [$];

   int unsigned mismatches;
   int unsigned n_replies;
   int unsigned op_seen [16];
   int unsigned status_seen [4];
   int unsigned hits_seen;

   // Performs one list operation on the expected contents and returns its response beat.
   function automatic rsp_type run_list_op(req_type r);
      rsp_type     o;
      int          hit;
      int unsigned k;
      o   = '0;
      hit = -1;
      case (r.opcode)
         OP_APPEND: begin
            if (list_count >= LIST_CAP) begin
               o.status = ST_FULL;
            end else begin
               list_words[list_count] = r.item_value;
               list_count++;
            end
         end
         OP_SET: begin
            if (r.position_in >= list_count) o.status = ST_RANGE;
            else list_words[r.position_in] = r.item_value;
         end
         OP_SET_EXT: begin
            if (r.position_in >= LIST_CAP) begin
               o.status = ST_RANGE;
            end else begin
               // slots between the old end and the new one read as zero
               if (r.position_in >= list_count) begin
                  for (k = list_count; k < r.position_in; k++) list_words[k] = '0;
                  list_count = 32'(r.position_in) + 1;
               end
               list_words[r.position_in] = r.item_value;
            end
         end
         OP_LOOKUP, OP_REM_ORD, OP_REM_SWAP: begin
            for (k = 0; k < list_count && hit < 0; k++)
               if (list_words[k] == r.item_value) hit = k;
            if (hit < 0) begin
               o.status = ST_NOT_FOUND;
            end else begin
               o.found          = 1'b1;
               o.match_position = hit[5:0];
               if (r.opcode == OP_REM_ORD) begin
                  for (k = hit + 1; k < list_count; k++) list_words[k - 1] = list_words[k];
                  list_count--;
               end else if (r.opcode == OP_REM_SWAP) begin
                  list_count--;
                  list_words[hit] = list_words[list_count];
               end
            end
         end
         OP_REM_POS: begin
            if (r.position_in >= list_count) begin
               o.status = ST_RANGE;
            end else begin
               for (k = 32'(r.position_in) + 1; k < list_count; k++)
                  list_words[k - 1] = list_words[k];
               list_count--;
            end
         end
         OP_CLEAR: list_count = 0;
         OP_RESIZE: begin
            if (r.new_length > LIST_CAP) begin
               o.status = ST_FULL;
            end else begin
               for (k = list_count; k < r.new_length; k++) list_words[k] = '0;
               list_count = 32'(r.new_length);
            end
         end
         default: ;   // undefined opcodes only report the count
      endcase
      o.length_now = list_count[6:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Random traffic, shaped by the current list so that searches hit and edges get reached
   // ---------------------------------------------------------------------------------------
   function automatic logic [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 4) return $urandom_range(7);                      // small pool: duplicates
      if (sel < 8 && list_count > 0) return list_words[$urandom_range(list_count - 1)];
      if (sel == 8) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      return $urandom;
   endfunction

   function automatic req_type gen_list_req();
      req_type     r;
      int unsigned sel;
      int unsigned top;
      r.opcode      = OP_APPEND;
      r.position_in = 6'($urandom);
      r.item_value  = $urandom;
      r.new_length  = 7'($urandom);
      sel = $urandom_range(99);
      if (list_count < 8 && sel < 30) sel = 0;                    // keep the list from starving
      if      (sel < 16) r.opcode = OP_APPEND;
      else if (sel < 28) r.opcode = OP_SET;
      else if (sel < 36) r.opcode = OP_SET_EXT;
      else if (sel < 50) r.opcode = OP_LOOKUP;
      else if (sel < 60) r.opcode = OP_REM_POS;
      else if (sel < 70) r.opcode = OP_REM_ORD;
      else if (sel < 80) r.opcode = OP_REM_SWAP;
      else if (sel < 82) r.opcode = OP_CLEAR;
      else if (sel < 94) r.opcode = OP_RESIZE;
      else if (sel < 97) r.opcode = 4'($urandom_range(15, 9));  // undefined codes
      else               r.opcode = OP_APPEND;

      if (r.opcode != OP_CLEAR && r.opcode != OP_RESIZE) r.item_value = pick_value();

      sel = $urandom_range(9);
      if (r.opcode == OP_SET || r.opcode == OP_REM_POS) begin
         if (sel < 8 && list_count > 0) r.position_in = 6'($urandom_range(list_count - 1));
      end else if (r.opcode == OP_SET_EXT) begin
         top = (list_count + 4 > 63) ? 63 : list_count + 4;
         if (sel < 3 && list_count > 0) r.position_in = 6'($urandom_range(list_count - 1));
         else if (sel < 8)
            r.position_in = 6'($urandom_range(top, (list_count > 63) ? 63 : list_count));
      end else if (r.opcode == OP_RESIZE) begin
         top = (list_count + 8 > LIST_CAP) ? LIST_CAP : list_count + 8;
         if (sel < 7)      r.new_length = 7'($urandom_range(top));
         else if (sel < 9) r.new_length = 7'($urandom_range(LIST_CAP));
         else              r.new_length = 7'($urandom_range(127, LIST_CAP + 1));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Directed table: reset state, extremes of every field and every corner case
   // ---------------------------------------------------------------------------------------
   typedef struct {
      req_type req;
      bit      typed;    // 1: response is given in the row, 0: taken from run_list_op
      rsp_type want;
   } plan_row_type;

   plan_row_type plan_rows [$];

   function automatic rsp_type mk_rsp(int f, int p, int n, logic [1:0] s);
      rsp_type o;
      o.found = f[0];  o.match_position = p[5:0];  o.length_now = n[6:0];  o.status = s;
      return o;
   endfunction

   task automatic add_row(input logic [3:0] op, input logic [5:0] pos, input logic [31:0] val,
                          input logic [6:0] nl, input int typed, input rsp_type want);
      plan_row_type row;
      row.req.opcode      = op;
      row.req.position_in = pos;
      row.req.item_value  = val;
      row.req.new_length  = nl;
      row.typed           = (typed != 0);
      row.want            = want;
      plan_rows.push_back(row);
   endtask

   task automatic fill_plan();
      // empty list: searches miss, positions are out of range
      add_row(OP_LOOKUP,   6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 0,  ST_NOT_FOUND));
      add_row(OP_REM_POS,  6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 0,  ST_RANGE));
      add_row(OP_SET,      6'd63, 32'hFFFF_FFFF, 7'd0,   1, mk_rsp(0, 0, 0,  ST_RANGE));
      add_row(OP_REM_ORD,  6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 0,  ST_NOT_FOUND));
      add_row(OP_REM_SWAP, 6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 0,  ST_NOT_FOUND));
      add_row(OP_APPEND,   6'd0,  32'hFFFF_FFFF, 7'd0,   1, mk_rsp(0, 0, 1,  ST_OK));
      add_row(OP_APPEND,   6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 2,  ST_OK));
      add_row(OP_LOOKUP,   6'd0,  32'h0,         7'd0,   1, mk_rsp(1, 1, 2,  ST_OK));
      // widest growth fills the list; the gap must read back as zero
      add_row(OP_SET_EXT,  6'd63, 32'h8000_0001, 7'd0,   1, mk_rsp(0, 0, 64, ST_OK));
      add_row(OP_APPEND,   6'd0,  32'h5,         7'd0,   1, mk_rsp(0, 0, 64, ST_FULL));
      add_row(OP_RESIZE,   6'd0,  32'h0,         7'd127, 1, mk_rsp(0, 0, 64, ST_FULL));
      add_row(OP_LOOKUP,   6'd0,  32'h8000_0001, 7'd0,   1, mk_rsp(1, 63, 64, ST_OK));
      add_row(OP_SET_EXT,  6'd63, 32'h7FFF_FFFE, 7'd0,   0, '0);
      add_row(OP_REM_SWAP, 6'd0,  32'h0,         7'd0,   0, '0);
      add_row(OP_REM_ORD,  6'd0,  32'hFFFF_FFFF, 7'd0,   0, '0);
      add_row(OP_REM_POS,  6'd0,  32'h0,         7'd0,   0, '0);
      add_row(OP_SET,      6'd5,  32'h1234_5678, 7'd0,   0, '0);
      // shrink then grow: the old word at slot 5 must be gone
      add_row(OP_RESIZE,   6'd0,  32'h0,         7'd3,   0, '0);
      add_row(OP_RESIZE,   6'd0,  32'h0,         7'd10,  0, '0);
      add_row(OP_LOOKUP,   6'd5,  32'h1234_5678, 7'd0,   0, '0);
      add_row(4'hF,        6'd63, 32'hFFFF_FFFF, 7'd127, 0, '0);
      add_row(OP_CLEAR,    6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 0,  ST_OK));
      add_row(OP_RESIZE,   6'd0,  32'h0,         7'd64,  1, mk_rsp(0, 0, 64, ST_OK));
      add_row(OP_LOOKUP,   6'd0,  32'h0,         7'd0,   1, mk_rsp(1, 0, 64, ST_OK));
      add_row(OP_RESIZE,   6'd0,  32'h0,         7'd0,   1, mk_rsp(0, 0, 0,  ST_OK));
      add_row(OP_SET_EXT,  6'd0,  32'h1,         7'd0,   1, mk_rsp(0, 0, 1,  ST_OK));
   endtask

   // ---------------------------------------------------------------------------------------
   // Request side: one beat in flight; start stays up until the beat is taken
   // ---------------------------------------------------------------------------------------
   int unsigned n_taken;
   int unsigned n_total;
   bit          beat_up;
   bit          cur_typed;
   rsp_type     cur_want;
   req_type     next_req;
   rsp_type     model_rsp;
   bit          quiet;

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      list_count =  0;
      for (int i = 0; i < LIST_CAP; i++) list_words[i] = '0;
      fill_plan();
      n_total = plan_rows.size() + RANDOM_BEATS;
      n_taken = 0;
      beat_up = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (n_taken < n_total) begin
         @(posedge clock);
         if (start && !busy) begin
            model_rsp = run_list_op(req_data);
            replies_due.push_back(cur_typed ? cur_want : model_rsp);
            op_seen[req_data.opcode]++;
            n_taken++;
            beat_up = 1'b0;
         end
         quiet = (n_taken >= QUIET_FROM && n_taken < QUIET_TO);
         // a new beat may go up while the engine is still busy with the last one
         if (!beat_up && n_taken < n_total && (quiet || $urandom_range(99) >= 12)) begin
            if (n_taken < plan_rows.size()) begin
               next_req  = plan_rows[n_taken].req;
               cur_typed = plan_rows[n_taken].typed;
               cur_want  = plan_rows[n_taken].want;
            end else begin
               next_req  = gen_list_req();
               cur_typed = 1'b0;
            end
            req_data <= next_req;
            beat_up  =  1'b1;
         end
         start <= beat_up;
      end

      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);   // catch stray responses

      $display("covered %0d request beats (%0d directed), %0d responses, %0d search hits",
               n_taken, plan_rows.size(), n_replies, hits_seen);
      $write("ops: app %0d set %0d ext %0d look %0d rpos %0d rord %0d rswp %0d clr %0d ",
             op_seen[OP_APPEND], op_seen[OP_SET], op_seen[OP_SET_EXT], op_seen[OP_LOOKUP],
             op_seen[OP_REM_POS], op_seen[OP_REM_ORD], op_seen[OP_REM_SWAP],
             op_seen[OP_CLEAR]);
      $display("rsz %0d; status ok %0d full %0d range %0d miss %0d",
               op_seen[OP_RESIZE], status_seen[ST_OK], status_seen[ST_FULL],
               status_seen[ST_RANGE], status_seen[ST_NOT_FOUND]);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("bounded_list_engine_unit_tb: done, clean");
      end else begin
         $display("bounded_list_engine_unit_tb: done, errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Response side: every strobed beat is compared with the oldest one due
   // ---------------------------------------------------------------------------------------
   rsp_type want_rsp;

   task automatic flag_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("MISMATCH %s: want found=%0d pos=%0d len=%0d st=%0d, ",
                what, want.found, want.match_position, want.length_now, want.status);
         $display("got found=%0d pos=%0d len=%0d st=%0d",
                  got.found, got.match_position, got.length_now, got.status);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         n_replies++;
         if (replies_due.size() == 0) begin
            flag_mismatch("unexpected beat", '0, rsp_data);
         end else begin
            want_rsp = replies_due.pop_front();
            if (rsp_data.found !== want_rsp.found ||
                rsp_data.match_position !== want_rsp.match_position ||
                rsp_data.length_now !== want_rsp.length_now ||
                rsp_data.status !== want_rsp.status)
               flag_mismatch("field", want_rsp, rsp_data);
            status_seen[want_rsp.status]++;
            if (want_rsp.found) hits_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: too long without any beat moving on either side ends the run
   // ---------------------------------------------------------------------------------------
   int unsigned stall_cycles;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", stall_cycles);
         $display("bounded_list_engine_unit_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
